### sv/radix_to_ascii_converter_unit_defines.svh
// Assertion macros for the radix to ASCII converter
`ifndef RADIX_TO_ASCII_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_TO_ASCII_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication
`define RTAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rtac_pkg.sv
// Shared constants, types and functions of the radix to ASCII converter
`timescale 1ns / 1ps

package rtac_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_BASE    = 16;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int SYM_W       = 8;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 2;

    localparam int STEP_BITS = 8;
    localparam int DIV_CYC   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W     = DIV_CYC * STEP_BITS;
    localparam int CHUNK_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int STORE_AW  = $clog2(VALUE_WIDTH);
    localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);

    localparam logic [IDX_W-1:0] CFG_BASE_SIZE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [SYM_W-1:0]  MINUS_SIGN = 8'h2D;
    localparam logic [SYM_W-1:0]  PRINT_MIN  = 8'd32;
    localparam logic [SYM_W-1:0]  PRINT_MAX  = 8'd126;

    typedef struct packed {
        logic load;
        logic step;
        logic clear_rem;
    } t_div_ctrl;

    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic               quot_zero;
    } t_div_stat;

    function automatic logic [SYM_W-1:0] symbol_of(input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi,
                                                   input logic [DIGIT_W-1:0] d);
        logic [5:0] pos;
        pos = {d[2:0], 3'b000};
        return d[3] ? hi[pos +: SYM_W] : lo[pos +: SYM_W];
    endfunction

endpackage

### sv/rtac_base_check.sv
// Validity check of the configured base size and digit alphabet
`timescale 1ns / 1ps

module rtac_base_check (
    input  logic [rtac_pkg::BASE_W-1:0] i_base_size,
    input  logic [rtac_pkg::CFG_W-1:0]  i_digits_low,
    input  logic [rtac_pkg::CFG_W-1:0]  i_digits_high,
    output logic                        o_base_ok
);

    logic [rtac_pkg::SYM_W-1:0] sym [rtac_pkg::MAX_BASE];
    logic [rtac_pkg::MAX_BASE-1:0] in_use;

    always_comb begin
        for (int i = 0; i < rtac_pkg::MAX_BASE; i++) begin
            sym[i]    = rtac_pkg::symbol_of(i_digits_low, i_digits_high,
                                            rtac_pkg::DIGIT_W'(i));
            in_use[i] = rtac_pkg::BASE_W'(i) < i_base_size;
        end
    end

    always_comb begin
        o_base_ok = (i_base_size >= rtac_pkg::BASE_W'(2)) &&
                    (i_base_size <= rtac_pkg::BASE_W'(rtac_pkg::MAX_BASE));
        for (int i = 0; i < rtac_pkg::MAX_BASE; i++) begin
            if (in_use[i] && (sym[i] < rtac_pkg::PRINT_MIN || sym[i] > rtac_pkg::PRINT_MAX))
                o_base_ok = 1'b0;
            for (int j = 0; j < i; j++) begin
                if (in_use[i] && sym[i] == sym[j])
                    o_base_ok = 1'b0;
            end
        end
    end

endmodule

### sv/rtac_div_unit.sv
// Shared restoring divider, several quotient bits per cycle while step is set
`timescale 1ns / 1ps

module rtac_div_unit (
    input  logic                             i_clk,
    input  rtac_pkg::t_div_ctrl              i_ctrl,
    input  logic [rtac_pkg::VALUE_WIDTH-1:0] i_mag,
    input  logic [rtac_pkg::BASE_W-1:0]      i_base,
    output rtac_pkg::t_div_stat              o_stat
);

    logic [rtac_pkg::DIV_W-1:0]   r_quot;
    logic [rtac_pkg::DIGIT_W-1:0] r_rem;
    logic [rtac_pkg::DIV_W-1:0]   n_quot;
    logic [rtac_pkg::DIGIT_W-1:0] n_rem;

    always_comb begin
        logic [rtac_pkg::BASE_W-1:0] t;
        logic                        ge;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int k = 0; k < rtac_pkg::STEP_BITS; k++) begin
            t      = {n_rem, n_quot[rtac_pkg::DIV_W-1]};
            ge     = t >= i_base;
            n_quot = {n_quot[rtac_pkg::DIV_W-2:0], ge};
            n_rem  = ge ? rtac_pkg::DIGIT_W'(t - i_base) : t[rtac_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quot <= rtac_pkg::DIV_W'(i_mag);
            r_rem  <= '0;
        end else if (i_ctrl.step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end else if (i_ctrl.clear_rem) begin
            r_rem  <= '0;
        end
    end

    assign o_stat.rem       = r_rem;
    assign o_stat.quot_zero = (r_quot == '0);

endmodule

### sv/rtac_digit_store.sv
// Digit store, least significant digit first, registered read
`timescale 1ns / 1ps

module rtac_digit_store (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [rtac_pkg::STORE_AW-1:0]    i_waddr,
    input  logic [rtac_pkg::DIGIT_W-1:0]     i_wdata,
    input  logic                             i_re,
    input  logic [rtac_pkg::STORE_AW-1:0]    i_raddr,
    output logic [rtac_pkg::DIGIT_W-1:0]     o_rdata
);

    logic [rtac_pkg::DIGIT_W-1:0] r_mem [rtac_pkg::VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re)
            o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/radix_to_ascii_converter_unit.sv
// A bad base gives its one word the cycle after start is taken.
// Otherwise each digit takes the shared divider through 4 steps of 8 bits (S_DIV) and 1 write (S_WRITE),
// then '-' if negative, then one digit word per cycle, the first after the store read, r_rd_vld and o_strobe.
// Busy covers division, emit and the last store read; the last word is out as busy drops.
// Output words cannot be stalled; a new start is taken once busy drops.
// Reset (synchronous, active low): idle, base size 10, digit alphabet all zero.
`timescale 1ns / 1ps
`include "radix_to_ascii_converter_unit_defines.svh"

module radix_to_ascii_converter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [31:0]               i_value,
    input  logic                             i_cfg_we,
    input  logic [rtac_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [rtac_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_strobe,
    output logic [rtac_pkg::SYM_W-1:0]       o_character,
    output logic                             o_bad_base,
    output logic                             o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_WRITE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                           r_state;
    logic [rtac_pkg::BASE_W-1:0]      r_base_size;
    logic [rtac_pkg::CFG_W-1:0]       r_digits_low;
    logic [rtac_pkg::CFG_W-1:0]       r_digits_high;
    logic                             r_neg;
    logic [rtac_pkg::CHUNK_W-1:0]     r_chunk;
    logic [rtac_pkg::CNT_W-1:0]       r_count;
    logic [rtac_pkg::CNT_W-1:0]       r_rdk;
    logic                             r_rd_vld;
    logic                             r_rd_last;

    logic                             base_ok;
    logic                             accept;
    logic [rtac_pkg::VALUE_WIDTH-1:0] raw;
    logic [rtac_pkg::VALUE_WIDTH-1:0] mag;
    logic [rtac_pkg::CNT_W-1:0]       n_count;
    logic [rtac_pkg::CNT_W-1:0]       n_rdk;
    logic                             div_done;
    logic [rtac_pkg::DIGIT_W-1:0]     rd_digit;
    rtac_pkg::t_div_ctrl              div_ctrl;
    rtac_pkg::t_div_stat              div_stat;

    assign raw     = i_value[rtac_pkg::VALUE_WIDTH-1:0];
    assign mag     = raw[rtac_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE) || r_rd_vld;
    assign n_count = r_count + 1'b1;
    assign n_rdk   = r_rdk - 1'b1;
    assign div_done = (r_state == S_WRITE) &&
                      (div_stat.quot_zero ||
                       n_count >= rtac_pkg::CNT_W'(rtac_pkg::VALUE_WIDTH));

    assign div_ctrl.load      = accept && base_ok;
    assign div_ctrl.step      = (r_state == S_DIV);
    assign div_ctrl.clear_rem = (r_state == S_WRITE);

    rtac_base_check u_base_check (
        .i_base_size   (r_base_size),
        .i_digits_low  (r_digits_low),
        .i_digits_high (r_digits_high),
        .o_base_ok     (base_ok)
    );

    rtac_div_unit u_div (
        .i_clk  (i_clk),
        .i_ctrl (div_ctrl),
        .i_mag  (mag),
        .i_base (r_base_size),
        .o_stat (div_stat)
    );

    rtac_digit_store u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_count[rtac_pkg::STORE_AW-1:0]),
        .i_wdata (div_stat.rem),
        .i_re    (r_state == S_EMIT),
        .i_raddr (n_rdk[rtac_pkg::STORE_AW-1:0]),
        .o_rdata (rd_digit)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size   <= rtac_pkg::BASE_RESET;
            r_digits_low  <= '0;
            r_digits_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtac_pkg::CFG_BASE_SIZE:   r_base_size   <= i_cfg_data[rtac_pkg::BASE_W-1:0];
                rtac_pkg::CFG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                rtac_pkg::CFG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_neg     <= 1'b0;
            r_chunk   <= '0;
            r_count   <= '0;
            r_rdk     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == S_EMIT);
            r_rd_last <= (r_rdk == rtac_pkg::CNT_W'(1));
            unique case (r_state)
                S_IDLE: begin
                    if (accept && base_ok) begin
                        r_neg   <= raw[rtac_pkg::VALUE_WIDTH-1];
                        r_chunk <= '0;
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_chunk == rtac_pkg::CHUNK_W'(rtac_pkg::DIV_CYC - 1)) begin
                        r_chunk <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_count <= n_count;
                    if (div_done) begin
                        r_rdk   <= n_count;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_EMIT: begin
                    r_rdk <= n_rdk;
                    if (r_rdk == rtac_pkg::CNT_W'(1))
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (accept && !base_ok) || (div_done && r_neg) || r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !base_ok) begin
            o_character <= '0;
            o_bad_base  <= 1'b1;
            o_last      <= 1'b1;
        end else if (div_done && r_neg) begin
            o_character <= rtac_pkg::MINUS_SIGN;
            o_bad_base  <= 1'b0;
            o_last      <= 1'b0;
        end else begin
            o_character <= rtac_pkg::symbol_of(r_digits_low, r_digits_high, rd_digit);
            o_bad_base  <= 1'b0;
            o_last      <= r_rd_last;
        end
    end

    `RTAC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_strobe, "accepted word neither busy nor answered")
    `RTAC_ASSERT_NOW(a_bad_base_word, i_clk, i_rst_n, o_strobe && o_bad_base, o_last && o_character == '0, "bad base word malformed")
    `RTAC_ASSERT_NOW(a_emit_count, i_clk, i_rst_n, r_state == S_EMIT, r_rdk != '0, "emit with no digits left")

endmodule

### verif/rtac_text_checker.sv
// Checker for the radix to ASCII converter: predicts the text of each value and compares words
`timescale 1ns / 1ps

module rtac_text_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic signed [31:0]               i_value,
    input  logic                             i_cfg_we,
    input  logic [rtac_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [rtac_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_strobe,
    input  logic [rtac_pkg::SYM_W-1:0]       i_character,
    input  logic                             i_bad_base,
    input  logic                             i_last,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [rtac_pkg::SYM_W-1:0] character;
        logic                       bad_base;
        logic                       last;
    } t_text_word;

    logic [rtac_pkg::BASE_W-1:0] radix;
    logic [rtac_pkg::CFG_W-1:0]  alphabet_lo;
    logic [rtac_pkg::CFG_W-1:0]  alphabet_hi;
    t_text_word                  text_words[$];
    int                          fail_count;

    function automatic logic [rtac_pkg::SYM_W-1:0] glyph(input logic [rtac_pkg::DIGIT_W-1:0] d);
        logic [rtac_pkg::CFG_W-1:0] word;
        word = d[3] ? alphabet_hi : alphabet_lo;
        return word[8 * d[2:0] +: rtac_pkg::SYM_W];
    endfunction

    function automatic bit alphabet_valid();
        logic [rtac_pkg::SYM_W-1:0] s;
        if (radix < 2 || radix > rtac_pkg::MAX_BASE)
            return 1'b0;
        for (int i = 0; i < radix; i++) begin
            s = glyph(i[rtac_pkg::DIGIT_W-1:0]);
            if (s < rtac_pkg::PRINT_MIN || s > rtac_pkg::PRINT_MAX)
                return 1'b0;
            for (int j = 0; j < i; j++)
                if (glyph(j[rtac_pkg::DIGIT_W-1:0]) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_text(input logic [31:0] raw);
        logic [rtac_pkg::DIGIT_W-1:0]     digit_buf[rtac_pkg::VALUE_WIDTH];
        logic [rtac_pkg::VALUE_WIDTH-1:0] mag;
        logic [rtac_pkg::VALUE_WIDTH-1:0] divisor;
        logic                             negative;
        int                               n;
        t_text_word                       w;
        if (!alphabet_valid()) begin
            w = '{character: '0, bad_base: 1'b1, last: 1'b1};
            text_words.push_back(w);
            return;
        end
        negative = raw[rtac_pkg::VALUE_WIDTH-1];
        mag      = negative ? (~raw[rtac_pkg::VALUE_WIDTH-1:0] + 1'b1)
                            : raw[rtac_pkg::VALUE_WIDTH-1:0];
        divisor  = rtac_pkg::VALUE_WIDTH'(radix);
        n        = 0;
        do begin
            digit_buf[n] = rtac_pkg::DIGIT_W'(mag % divisor);
            n++;
            mag = mag / divisor;
        end while (mag != 0 && n < rtac_pkg::VALUE_WIDTH);
        if (negative) begin
            w = '{character: rtac_pkg::MINUS_SIGN, bad_base: 1'b0, last: 1'b0};
            text_words.push_back(w);
        end
        for (int k = n; k > 0; k--) begin
            w = '{character: glyph(digit_buf[k-1]), bad_base: 1'b0, last: (k == 1)};
            text_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_text_word want;
        if (!i_rst_n) begin
            radix       = rtac_pkg::BASE_RESET;
            alphabet_lo = '0;
            alphabet_hi = '0;
            text_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtac_pkg::CFG_BASE_SIZE:   radix = i_cfg_data[rtac_pkg::BASE_W-1:0];
                    rtac_pkg::CFG_DIGITS_LOW:  alphabet_lo = i_cfg_data;
                    rtac_pkg::CFG_DIGITS_HIGH: alphabet_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predict_text(i_value);
            if (i_strobe) begin
                if (text_words.size() == 0) begin
                    $display("%0t: unexpected word: character %h bad_base %b last %b",
                             $time, i_character, i_bad_base, i_last);
                    fail_count++;
                end else begin
                    want = text_words.pop_front();
                    if (i_character !== want.character) begin
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.character, i_character);
                        fail_count++;
                    end
                    if (i_bad_base !== want.bad_base) begin
                        $display("%0t: bad_base mismatch: expected %b, actual %b",
                                 $time, want.bad_base, i_bad_base);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, i_last);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    = text_words.size();
        o_fail_count = fail_count;
    end

endmodule

### verif/tb.sv
// Testbench top for the radix to ASCII converter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;

    localparam int                          CYCLE_LIMIT = 400000;
    localparam logic [rtac_pkg::IDX_W-1:0]  CFG_SPARE   = 2'd3;
    localparam logic [rtac_pkg::CFG_W-1:0]  DEC_LO      = 64'h3736353433323130;
    localparam logic [rtac_pkg::CFG_W-1:0]  HEX_HI      = 64'h4645444342413938;
    localparam logic signed [31:0]          INT_MIN     = 32'sh80000000;
    localparam logic signed [31:0]          INT_MAX     = 32'sh7FFFFFFF;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [31:0]            value;
    logic                          cfg_we;
    logic [rtac_pkg::IDX_W-1:0]    cfg_index;
    logic [rtac_pkg::CFG_W-1:0]    cfg_data;
    logic                          strobe;
    logic [rtac_pkg::SYM_W-1:0]    character;
    logic                          bad_base;
    logic                          last;
    int                            fail_count;
    int                            pending;
    int                            cycle_count;
    bit                            allow_idle;

    radix_to_ascii_converter_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (value),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_strobe    (strobe),
        .o_character (character),
        .o_bad_base  (bad_base),
        .o_last      (last)
    );

    rtac_text_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (value),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_strobe     (strobe),
        .i_character  (character),
        .i_bad_base   (bad_base),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_value(input logic signed [31:0] v);
        while (allow_idle && $urandom_range(99) < 37) begin
            start <= 1'b0;
            value <= $urandom;
            @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rtac_pkg::IDX_W-1:0] idx,
                             input logic [rtac_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic configure(input logic [rtac_pkg::BASE_W-1:0] b,
                             input logic [rtac_pkg::CFG_W-1:0] lo,
                             input logic [rtac_pkg::CFG_W-1:0] hi);
        logic [rtac_pkg::CFG_W-1:0] base_word;
        settle();
        base_word = {$urandom, $urandom};
        base_word[rtac_pkg::BASE_W-1:0] = b;
        write_reg(rtac_pkg::CFG_BASE_SIZE, base_word);
        write_reg(rtac_pkg::CFG_DIGITS_LOW, lo);
        write_reg(rtac_pkg::CFG_DIGITS_HIGH, hi);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // flaw: 0 clean, 1 repeated symbol, 2 unprintable symbol, 3 junk only past the base
    task automatic random_alphabet(input logic [rtac_pkg::BASE_W-1:0] b, input int flaw,
                                   output logic [rtac_pkg::CFG_W-1:0] lo,
                                   output logic [rtac_pkg::CFG_W-1:0] hi);
        logic [7:0] pool[95];
        logic [7:0] sym[16];
        logic [7:0] tmp;
        int         j;
        int         i;
        int         limit;
        for (int k = 0; k < 95; k++)
            pool[k] = 8'd32 + k[7:0];
        for (int k = 0; k < 16; k++) begin
            j       = $urandom_range(94, k);
            tmp     = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
            sym[k]  = pool[k];
        end
        limit = (b > 16) ? 16 : b;
        if (flaw == 3 || limit < 16) begin
            for (int k = limit; k < 16; k++)
                sym[k] = 8'($urandom_range(255));
        end
        if (limit >= 2) begin
            if (flaw == 1) begin
                j      = $urandom_range(limit - 1, 1);
                i      = $urandom_range(j - 1, 0);
                sym[j] = sym[i];
            end else if (flaw == 2) begin
                j      = $urandom_range(limit - 1, 0);
                sym[j] = $urandom_range(1) ? 8'($urandom_range(31))
                                           : 8'($urandom_range(255, 127));
            end
        end
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = sym[k];
            hi[8*k +: 8] = sym[k+8];
        end
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 32'($urandom_range(40)) : -32'($urandom_range(40));
            1: return INT_MIN;
            2: return INT_MAX;
            3: return $urandom_range(1) ? -32'sd1 : 32'sd0;
            4: return $signed($urandom_range(65535)) * ($urandom_range(1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [rtac_pkg::CFG_W-1:0]  lo;
        logic [rtac_pkg::CFG_W-1:0]  hi;
        logic [rtac_pkg::BASE_W-1:0] b;
        int                          flaw;
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        allow_idle  = 1'b1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset alphabet is all zero, so the base is rejected
        send_value(32'sd5);
        send_value(INT_MIN);

        configure(5'd10, DEC_LO, HEX_HI);
        send_value(32'sd0);
        send_value(32'sd7);
        send_value(-32'sd1);
        send_value(INT_MAX);
        send_value(INT_MIN);
        send_value(-32'sd10);
        send_value(32'sd1000000);

        configure(5'd2, DEC_LO, HEX_HI);
        send_value(INT_MIN);
        send_value(-32'sd1);
        send_value(INT_MAX);

        configure(5'd16, DEC_LO, HEX_HI);
        send_value(32'shDEADBEEF);
        send_value(32'sd255);

        configure(5'd0, DEC_LO, HEX_HI);
        send_value(32'sd3);
        configure(5'd1, DEC_LO, HEX_HI);
        send_value(32'sd3);
        configure(5'd17, DEC_LO, HEX_HI);
        send_value(32'sd3);

        configure(5'd16, DEC_LO, {8'h39, HEX_HI[55:0]});
        send_value(32'sd42);
        configure(5'd16, DEC_LO, {8'h7F, HEX_HI[55:0]});
        send_value(32'sd42);
        configure(5'd16, {DEC_LO[63:8], 8'h1F}, HEX_HI);
        send_value(32'sd42);

        // symbols past the base are ignored
        configure(5'd8, DEC_LO, {rtac_pkg::CFG_W{1'b1}});
        write_reg(CFG_SPARE, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(negedge clk);
        send_value(-32'sd8);
        send_value(32'sd63);

        for (int phase = 0; phase < 10; phase++) begin
            if ($urandom_range(9) == 0)
                b = $urandom_range(1) ? rtac_pkg::BASE_W'($urandom_range(1))
                                      : rtac_pkg::BASE_W'($urandom_range(31, 17));
            else
                b = (phase == 0) ? 5'd2 : (phase == 1) ? 5'd16
                                        : rtac_pkg::BASE_W'($urandom_range(16, 2));
            flaw = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : $urandom_range(1) * 3;
            random_alphabet(b, flaw, lo, hi);
            configure(b, lo, hi);
            allow_idle = (phase != 3);
            repeat (13) send_value(random_value());
        end
        allow_idle = 1'b1;

        settle();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
